[hdl/rcapd_pkg.sv]
// shared constants, types and decision struct for the copy-above run-length pixel decoder
package rcapd_pkg;

	localparam int LINE_DEPTH = 256;
	localparam int ADDR_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
	localparam int BYTE_W     = 8;
	localparam int RUN_W      = 13;
	localparam int COUNT_W    = 16;
	localparam int CFG_IDX_W  = 1;

	typedef logic [BYTE_W-1:0]    byte_t;
	typedef logic [RUN_W-1:0]     run_t;
	typedef logic [COUNT_W-1:0]   count_t;
	typedef logic [1:0]           kind_t;
	typedef logic [ADDR_W-1:0]    addr_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	// run kinds
	localparam kind_t KIND_NONE    = 2'd0;
	localparam kind_t KIND_REPEAT  = 2'd1;
	localparam kind_t KIND_LITERAL = 2'd2;
	localparam kind_t KIND_COPY    = 2'd3;

	// header ranges
	localparam byte_t HDR_LITERAL_BASE = 8'd85;
	localparam byte_t HDR_COPY_BASE    = 8'd170;
	localparam run_t  LITERAL_BIAS     = 13'd84;
	localparam run_t  COPY_BIAS        = 13'd169;
	localparam run_t  RUN_SCALE        = 13'd85;

	// configuration register indexes
	localparam cfg_idx_t CFG_PICTURE_SIZE = 1'd0;
	localparam cfg_idx_t CFG_RAW_MODE     = 1'd1;

	// decision taken for one transaction, handed from the run controller to the pipeline
	typedef struct packed {
		logic  taken;
		logic  emit;
		logic  sel_above;
		logic  above_zero;
		logic  col_ok;
		logic  last;
		byte_t value;
		addr_t addr;
	} step_t;

endpackage

[hdl/rcapd_if.sv]
// channel interfaces: compressed byte input, pixel output and configuration writes
interface rcapd_byte_if;
	logic                  valid;
	logic                  ready;
	logic                  byte_valid;
	logic [7:0]            in_byte;

	modport source (output valid, output byte_valid, output in_byte, input ready);
	modport sink (input valid, input byte_valid, input in_byte, output ready);
endinterface

interface rcapd_pix_if;
	logic                  valid;
	logic                  ready;
	logic                  byte_taken;
	logic                  pixel_valid;
	logic [7:0]            pixel;
	logic                  last_pixel;

	modport source (output valid, output byte_taken, output pixel_valid, output pixel,
		output last_pixel, input ready);
	modport sink (input valid, input byte_taken, input pixel_valid, input pixel,
		input last_pixel, output ready);
endinterface

interface rcapd_cfg_if;
	logic                  valid;
	logic                  ready;
	logic [0:0]            index;
	logic [7:0]            data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

[hdl/rle_copy_above_pixel_decoder_top.sv]
// top level: configuration registers, line store memory and the two-stage result pipeline
// The decoder takes one transaction per clock cycle when the output side is ready, passing it
// through the stage 1 and stage 2 registers. Run decoding and the picture position advance in
// the cycle a transaction is accepted; copy-above pixels come from a 256-entry line store with
// one write and one registered read per cycle, read in the accept cycle and written back when
// the result leaves the first stage, with a bypass when both hit the same column. Two results
// can wait inside the block before input back-pressure shows. Configuration writes are always
// ready and must only be issued while no transaction is in flight.
module rle_copy_above_pixel_decoder_top (
	input  logic        clk,
	input  logic        arst_n,
	rcapd_byte_if.sink  bytes,
	rcapd_pix_if.source pixels,
	rcapd_cfg_if.sink   cfg
);

	rcapd_pkg::byte_t  picture_size_q;
	logic              raw_mode_q;
	rcapd_pkg::count_t total_q;

	rcapd_pkg::step_t  step;
	logic              accept;
	logic              adv_s1;

	logic              valid_s1;
	rcapd_pkg::step_t  dec_s1;
	rcapd_pkg::byte_t  rd_data_s1;
	logic              fwd_s1;
	rcapd_pkg::byte_t  fwd_data_s1;
	rcapd_pkg::byte_t  above_s1;
	rcapd_pkg::byte_t  pixel_s1;
	logic              wr_en;

	logic              valid_s2;
	logic              taken_s2;
	logic              pixel_valid_s2;
	rcapd_pkg::byte_t  pixel_s2;
	logic              last_s2;

	rcapd_pkg::byte_t  line_mem [rcapd_pkg::LINE_DEPTH];

	// configuration
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			picture_size_q <= '0;
			raw_mode_q     <= 1'b0;
			total_q        <= '0;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				rcapd_pkg::CFG_PICTURE_SIZE: begin
					picture_size_q <= cfg.data;
					total_q        <= rcapd_pkg::count_t'(cfg.data)
						* rcapd_pkg::count_t'(cfg.data);
				end
				rcapd_pkg::CFG_RAW_MODE: begin
					raw_mode_q <= cfg.data[0];
				end
				default: begin
					raw_mode_q <= raw_mode_q;
				end
			endcase
		end
	end

	// handshake
	assign adv_s1      = valid_s1 && (!valid_s2 || pixels.ready);
	assign bytes.ready = !valid_s1 || adv_s1;
	assign accept      = bytes.valid && bytes.ready;

	rcapd_run_ctrl u_run_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.step_en      (accept),
		.byte_valid   (bytes.byte_valid),
		.in_byte      (bytes.in_byte),
		.picture_size (picture_size_q),
		.raw_mode     (raw_mode_q),
		.total        (total_q),
		.step         (step)
	);

	// stage 1: line store read data arrives, pixel is resolved
	assign above_s1 = dec_s1.above_zero ? '0 : (fwd_s1 ? fwd_data_s1 : rd_data_s1);
	assign pixel_s1 = dec_s1.sel_above ? above_s1 : dec_s1.value;
	assign wr_en    = adv_s1 && dec_s1.emit && dec_s1.col_ok;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			line_mem[dec_s1.addr] <= pixel_s1;
		end
		if (accept) begin
			rd_data_s1  <= line_mem[step.addr];
			// same-edge write to the column being read
			fwd_s1      <= wr_en && (dec_s1.addr == step.addr);
			fwd_data_s1 <= pixel_s1;
			dec_s1      <= step;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// stage 2: output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= 1'b1;
		end else if (pixels.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			taken_s2       <= dec_s1.taken;
			pixel_valid_s2 <= dec_s1.emit;
			pixel_s2       <= dec_s1.emit ? pixel_s1 : '0;
			last_s2        <= dec_s1.last;
		end
	end

	assign pixels.valid       = valid_s2;
	assign pixels.byte_taken  = taken_s2;
	assign pixels.pixel_valid = pixel_valid_s2;
	assign pixels.pixel       = pixel_s2;
	assign pixels.last_pixel  = last_s2;

endmodule

[hdl/rcapd_run_ctrl.sv]
// run state registers and per-transaction decoding of headers, runs and picture position
module rcapd_run_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step_en,
	input  logic                  byte_valid,
	input  rcapd_pkg::byte_t      in_byte,
	input  rcapd_pkg::byte_t      picture_size,
	input  logic                  raw_mode,
	input  rcapd_pkg::count_t     total,
	output rcapd_pkg::step_t      step
);

	rcapd_pkg::run_t   run_left_q, run_left_d;
	rcapd_pkg::kind_t  run_kind_q, run_kind_d;
	rcapd_pkg::byte_t  held_value_q, held_value_d;
	logic              awaiting_q, awaiting_d;
	rcapd_pkg::count_t pixel_count_q, pixel_count_d;
	rcapd_pkg::byte_t  column_q, column_d;

	rcapd_pkg::run_t   byte_run;
	rcapd_pkg::run_t   repeat_scaled;
	rcapd_pkg::run_t   copy_len;
	rcapd_pkg::run_t   copy_scaled;
	logic              picture_done;
	logic [8:0]        column_inc;

	assign byte_run      = rcapd_pkg::run_t'(in_byte);
	assign repeat_scaled = rcapd_pkg::run_t'(run_left_q * rcapd_pkg::RUN_SCALE);
	assign copy_len      = byte_run - rcapd_pkg::COPY_BIAS;
	assign copy_scaled   = rcapd_pkg::run_t'(copy_len * rcapd_pkg::RUN_SCALE);
	assign picture_done  = ({1'b0, pixel_count_q} + 17'd1) >= {1'b0, total};
	assign column_inc    = {1'b0, column_q} + 9'd1;

	always_comb begin
		run_left_d    = run_left_q;
		run_kind_d    = run_kind_q;
		held_value_d  = held_value_q;
		awaiting_d    = awaiting_q;
		pixel_count_d = pixel_count_q;
		column_d      = column_q;
		step          = '0;
		step.addr       = rcapd_pkg::addr_t'(column_q);
		step.col_ok     = {1'b0, column_q} < 9'(rcapd_pkg::LINE_DEPTH);
		step.above_zero = (pixel_count_q < rcapd_pkg::count_t'(picture_size)) || !step.col_ok;

		if (picture_size != '0) begin
			if (raw_mode) begin
				if (byte_valid) begin
					step.taken = 1'b1;
					step.emit  = 1'b1;
					step.value = in_byte;
				end
			end else if (awaiting_q) begin
				if (byte_valid) begin
					step.taken = 1'b1;
					step.emit  = 1'b1;
					step.value = in_byte;
					// a repeat of the same value stretches the run by the scale factor
					if (run_kind_q == rcapd_pkg::KIND_REPEAT && in_byte == held_value_q) begin
						run_left_d = repeat_scaled - 13'd1;
					end else begin
						run_left_d = run_left_q;
					end
					held_value_d = in_byte;
					run_kind_d   = rcapd_pkg::KIND_REPEAT;
					awaiting_d   = 1'b0;
				end
			end else if (run_left_q == '0) begin
				if (byte_valid) begin
					step.taken = 1'b1;
					if (in_byte < rcapd_pkg::HDR_LITERAL_BASE) begin
						run_left_d = byte_run + 13'd1;
						awaiting_d = 1'b1;
					end else if (in_byte < rcapd_pkg::HDR_COPY_BASE) begin
						run_left_d = byte_run - rcapd_pkg::LITERAL_BIAS;
						run_kind_d = rcapd_pkg::KIND_LITERAL;
					end else begin
						if (run_kind_q == rcapd_pkg::KIND_COPY) begin
							run_left_d = copy_scaled - 13'd1;
						end else begin
							run_left_d = copy_len - 13'd1;
						end
						run_kind_d     = rcapd_pkg::KIND_COPY;
						step.emit      = 1'b1;
						step.sel_above = 1'b1;
					end
				end
			end else begin
				case (run_kind_q)
					rcapd_pkg::KIND_LITERAL: begin
						if (byte_valid) begin
							step.taken = 1'b1;
							step.emit  = 1'b1;
							step.value = in_byte;
							run_left_d = run_left_q - 13'd1;
						end
					end
					rcapd_pkg::KIND_COPY: begin
						step.emit      = 1'b1;
						step.sel_above = 1'b1;
						run_left_d     = run_left_q - 13'd1;
					end
					default: begin
						step.emit  = 1'b1;
						step.value = held_value_q;
						run_left_d = run_left_q - 13'd1;
					end
				endcase
			end
		end

		if (step.emit) begin
			if (picture_done) begin
				// end of picture: any leftover run is dropped
				step.last     = 1'b1;
				run_left_d    = '0;
				run_kind_d    = rcapd_pkg::KIND_NONE;
				held_value_d  = '0;
				awaiting_d    = 1'b0;
				pixel_count_d = '0;
				column_d      = '0;
			end else begin
				pixel_count_d = pixel_count_q + 16'd1;
				column_d      = (column_inc >= {1'b0, picture_size}) ? '0 : column_inc[7:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_left_q    <= '0;
			run_kind_q    <= rcapd_pkg::KIND_NONE;
			held_value_q  <= '0;
			awaiting_q    <= 1'b0;
			pixel_count_q <= '0;
			column_q      <= '0;
		end else if (step_en) begin
			run_left_q    <= run_left_d;
			run_kind_q    <= run_kind_d;
			held_value_q  <= held_value_d;
			awaiting_q    <= awaiting_d;
			pixel_count_q <= pixel_count_d;
			column_q      <= column_d;
		end
	end

endmodule

[hdl/rcapd_checker.sv]
// port-level checker for the decoder, bound to the top level
module rcapd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic       byte_taken,
	input logic       pixel_valid,
	input logic [7:0] pixel,
	input logic       last_pixel
);

	// a stalled result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pixel) && $stable(pixel_valid)
			&& $stable(last_pixel) && $stable(byte_taken))
		else $error("result changed while stalled");

	// no pixel means zero value and no end flag
	a_empty_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !pixel_valid |-> pixel == 8'd0 && !last_pixel)
		else $error("empty result carries pixel data");

	// end of picture only on a real pixel
	a_last_has_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_pixel |-> pixel_valid)
		else $error("last flag without pixel");

	// a rising output valid comes from an accepted transaction that did not wait in stage 1
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result without accepted transaction");

endmodule

bind rle_copy_above_pixel_decoder_top rcapd_checker u_rcapd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (bytes.valid),
	.in_ready    (bytes.ready),
	.out_valid   (pixels.valid),
	.out_ready   (pixels.ready),
	.byte_taken  (pixels.byte_taken),
	.pixel_valid (pixels.pixel_valid),
	.pixel       (pixels.pixel),
	.last_pixel  (pixels.last_pixel)
);
